// ===== sv/bm3_pkg.sv =====
// Package for the 3x3 binary erosion/dilation block.
// Holds field widths, register index codes, mode codes and the shared structs.
// No dependencies; all files of the block but bm3_in_if and bm3_ram import it.
package bm3_pkg;

  // Default size limits of the line stores and the frame.
  localparam int BM3_MAX_WIDTH  = 1024;
  localparam int BM3_MAX_HEIGHT = 1024;

  // Configuration port.
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  // Smallest usable frame side and the register reset values.
  localparam int              MIN_SIZE = 3;
  localparam logic [CFG_W-1:0] FW_RESET = 11'd64;
  localparam logic [CFG_W-1:0] FH_RESET = 11'd64;

  // 3x3 window.
  localparam int                WIN_N    = 9;
  localparam logic [WIN_N-1:0]  WIN_FULL = '1;

  // Saturating count of set output pixels.
  localparam int                ONES_W   = 21;
  localparam logic [ONES_W-1:0] ONES_MAX = '1;

  // Line store word: bit 0 is the upper row, bit 1 the middle row.
  localparam int LS_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_MORPH_MODE   = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    MODE_ERODE  = 1'b0,
    MODE_DILATE = 1'b1
  } morph_mode_e;

  // Sequencer states: line store clearing, division load, division steps, idle.
  typedef enum logic [1:0] {
    SEQ_CLEAR = 2'd0,
    SEQ_LOAD  = 2'd1,
    SEQ_DIV   = 2'd2,
    SEQ_IDLE  = 2'd3
  } seq_state_e;

  // Per-item flags worked out when the item is accepted.
  typedef struct packed {
    logic pix;
    logic produce;
    logic interior;
    logic last;
  } bm3_item_t;

  // Sequencer control towards the top level.
  typedef struct packed {
    logic busy;
    logic clr_we;
    logic upd;
  } seq_ctrl_t;

endpackage

// ===== sv/bm3_in_if.sv =====
// Input stream channel of the morphology block: valid/ready plus the pixel fields.
// Depends on nothing but plain logic types.
interface bm3_in_if;
  logic valid;
  logic ready;
  logic pixel_in;
  logic drain;

  modport source (output valid, output pixel_in, output drain, input ready);
  modport sink   (input valid, input pixel_in, input drain, output ready);
endinterface

// ===== sv/bm3_out_if.sv =====
// Result stream channel of the morphology block: valid/ready plus the result fields.
// Depends on bm3_pkg for the width of the running count.
interface bm3_out_if import bm3_pkg::*; ;
  logic              valid;
  logic              ready;
  logic              pixel_out;
  logic              frame_end;
  logic [ONES_W-1:0] set_total;

  modport source (output valid, output pixel_out, output frame_end, output set_total,
                  input ready);
  modport sink   (input valid, input pixel_out, input frame_end, input set_total,
                  output ready);
endinterface

// ===== sv/binary_morphology_3x3.sv =====
// Streaming 3x3 binary erosion/dilation with two line stores in one RAM.
// Throughput: one pixel transaction per cycle while the sequencer is idle, no register
// is written and no result waits in a full result register; a result passes the window
// stage, then the result register. After reset the line store is cleared, then the
// positions are rebuilt by a serial divider; each register write reruns that divider,
// and no pixel is accepted during the write or while the divider runs.
module binary_morphology_3x3 import bm3_pkg::*; #(
  parameter int MAX_WIDTH  = BM3_MAX_WIDTH,
  parameter int MAX_HEIGHT = BM3_MAX_HEIGHT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  bm3_in_if.sink               in_ch,
  bm3_out_if.source            out_ch
);

  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int POS_W = WW + HW;

  logic [CFG_W-1:0] fw_q, fh_q;
  morph_mode_e      mode_q;
  logic [WW-1:0]    w_clamp, w_q, wm1_q;
  logic [HW-1:0]    h_clamp, hm1_q;
  logic [POS_W-1:0] total_q, totalm1_q, prod;
  logic [POS_W-1:0] q_q, c_q, cy_q, cy_next;
  logic [XW-1:0]    x_q, cx_q, x_next, cx_next;
  logic             x_wrap, cx_wrap;
  logic             in_acc, s1_ready;
  bm3_item_t        item;
  seq_ctrl_t        seq_ctrl;
  logic [XW-1:0]    clr_addr, seq_x, seq_cx;
  logic [POS_W-1:0] seq_cy;
  logic             pipe_we;
  logic [XW-1:0]    pipe_waddr;
  logic [LS_W-1:0]  pipe_wdata, ls_rdata;
  logic             ram_we;
  logic [XW-1:0]    ram_waddr;
  logic [LS_W-1:0]  ram_wdata;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q   <= FW_RESET;
      fh_q   <= FH_RESET;
      mode_q <= MODE_ERODE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAME_WIDTH:  fw_q   <= cfg_data_i;
        CFG_FRAME_HEIGHT: fh_q   <= cfg_data_i;
        CFG_MORPH_MODE:   mode_q <= morph_mode_e'(cfg_data_i[0]);
        default: ;
      endcase
    end
  end

  // Frame sizes clamped to the supported range, and the pixel count of a frame.
  always_comb begin
    if (fw_q < CFG_W'(MIN_SIZE)) begin
      w_clamp = WW'(MIN_SIZE);
    end else if (int'(fw_q) > MAX_WIDTH) begin
      w_clamp = WW'(MAX_WIDTH);
    end else begin
      w_clamp = WW'(fw_q);
    end
    if (fh_q < CFG_W'(MIN_SIZE)) begin
      h_clamp = HW'(MIN_SIZE);
    end else if (int'(fh_q) > MAX_HEIGHT) begin
      h_clamp = HW'(MAX_HEIGHT);
    end else begin
      h_clamp = HW'(fh_q);
    end
    prod = POS_W'(w_clamp) * POS_W'(h_clamp);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q       <= WW'(MIN_SIZE);
      wm1_q     <= WW'(MIN_SIZE - 1);
      hm1_q     <= HW'(MIN_SIZE - 1);
      total_q   <= POS_W'(MIN_SIZE * MIN_SIZE);
      totalm1_q <= POS_W'(MIN_SIZE * MIN_SIZE - 1);
    end else begin
      w_q       <= w_clamp;
      wm1_q     <= w_clamp - WW'(1);
      hm1_q     <= h_clamp - HW'(1);
      total_q   <= prod;
      totalm1_q <= prod - POS_W'(1);
    end
  end

  // Input handshake: no transaction while the sequencer runs or a register is written.
  assign in_ch.ready  = !seq_ctrl.busy && !cfg_we_i && s1_ready;
  assign in_acc       = in_ch.valid && in_ch.ready;

  // Flags of the accepted item, from the positions before it.
  always_comb begin
    item.produce  = q_q > POS_W'(w_q);
    item.last     = c_q >= totalm1_q;
    item.pix      = !in_ch.drain && (q_q < total_q) && in_ch.pixel_in;
    item.interior = (cy_q != '0) && (cy_q < POS_W'(hm1_q)) &&
                    (cx_q != '0) && (WW'(cx_q) != wm1_q);
    x_wrap  = (WW'(x_q) + WW'(1)) == w_q;
    cx_wrap = (WW'(cx_q) + WW'(1)) == w_q;
    x_next  = x_wrap ? '0 : x_q + XW'(1);
    cx_next = cx_wrap ? '0 : cx_q + XW'(1);
    cy_next = cx_wrap ? cy_q + POS_W'(1) : cy_q;
  end

  // Input and output positions; the sequencer rebuilds the column and row after a write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q  <= '0;
      c_q  <= '0;
      x_q  <= '0;
      cx_q <= '0;
      cy_q <= '0;
    end else if (seq_ctrl.upd) begin
      x_q  <= seq_x;
      cx_q <= seq_cx;
      cy_q <= seq_cy;
    end else if (in_acc) begin
      if (item.produce && item.last) begin
        q_q  <= '0;
        c_q  <= '0;
        x_q  <= '0;
        cx_q <= '0;
        cy_q <= '0;
      end else begin
        q_q <= q_q + POS_W'(1);
        x_q <= x_next;
        if (item.produce) begin
          c_q  <= c_q + POS_W'(1);
          cx_q <= cx_next;
          cy_q <= cy_next;
        end
      end
    end
  end

  bm3_seq #(
    .MAX_WIDTH (MAX_WIDTH),
    .XW        (XW),
    .WW        (WW),
    .POS_W     (POS_W)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_write_i (cfg_we_i),
    .w_i         (w_q),
    .q_i         (q_q),
    .c_i         (c_q),
    .ctrl_o      (seq_ctrl),
    .clr_addr_o  (clr_addr),
    .x_o         (seq_x),
    .cx_o        (seq_cx),
    .cy_o        (seq_cy)
  );

  // Line store write: zeros during the clearing pass, otherwise the window stage.
  assign ram_we    = seq_ctrl.clr_we || pipe_we;
  assign ram_waddr = seq_ctrl.clr_we ? clr_addr : pipe_waddr;
  assign ram_wdata = seq_ctrl.clr_we ? '0 : pipe_wdata;

  bm3_ram #(
    .WIDTH (LS_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_acc),
    .raddr_i (x_q),
    .rdata_o (ls_rdata)
  );

  bm3_pipe #(
    .XW (XW)
  ) u_pipe (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (in_acc),
    .item_i     (item),
    .x_i        (x_q),
    .mode_i     (mode_q),
    .ls_rdata_i (ls_rdata),
    .s1_ready_o (s1_ready),
    .wr_en_o    (pipe_we),
    .wr_addr_o  (pipe_waddr),
    .wr_data_o  (pipe_wdata),
    .out_ch     (out_ch)
  );

endmodule

// ===== sv/bm3_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bm3_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/bm3_seq.sv =====
// Sequencer: clears the line store after reset and recomputes the column and row
// positions by restoring division after a register write. Depends on bm3_pkg.
module bm3_seq import bm3_pkg::*; #(
  parameter int MAX_WIDTH = BM3_MAX_WIDTH,
  parameter int XW        = 10,
  parameter int WW        = 11,
  parameter int POS_W     = 22
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_write_i,
  input  logic [WW-1:0]    w_i,
  input  logic [POS_W-1:0] q_i,
  input  logic [POS_W-1:0] c_i,
  output seq_ctrl_t        ctrl_o,
  output logic [XW-1:0]    clr_addr_o,
  output logic [XW-1:0]    x_o,
  output logic [XW-1:0]    cx_o,
  output logic [POS_W-1:0] cy_o
);

  localparam int CNTW = $clog2(POS_W);

  seq_state_e       state_q, state_d;
  logic [XW-1:0]    clr_addr_q;
  logic [CNTW-1:0]  cnt_q;
  logic [POS_W-1:0] nq_q, nq_d, nc_q, nc_d;
  logic [WW-1:0]    rq_q, rq_d, rc_q, rc_d;
  logic [WW:0]      tq, tc;
  logic             geq_q, geq_c;

  // One restoring division step for the input position and the output position.
  always_comb begin
    tq    = {rq_q, nq_q[POS_W-1]};
    tc    = {rc_q, nc_q[POS_W-1]};
    geq_q = tq >= {1'b0, w_i};
    geq_c = tc >= {1'b0, w_i};
    rq_d  = geq_q ? WW'(tq - {1'b0, w_i}) : WW'(tq);
    rc_d  = geq_c ? WW'(tc - {1'b0, w_i}) : WW'(tc);
    nq_d  = {nq_q[POS_W-2:0], 1'b0};
    nc_d  = {nc_q[POS_W-2:0], geq_c};
  end

  assign x_o        = XW'(rq_d);
  assign cx_o       = XW'(rc_d);
  assign cy_o       = nc_d;
  assign clr_addr_o = clr_addr_q;

  // Next state and control outputs.
  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    case (state_q)
      SEQ_CLEAR: begin
        ctrl_o.busy   = 1'b1;
        ctrl_o.clr_we = 1'b1;
        if (clr_addr_q == XW'(MAX_WIDTH - 1)) begin
          state_d = SEQ_LOAD;
        end
      end
      SEQ_LOAD: begin
        ctrl_o.busy = 1'b1;
        state_d     = SEQ_DIV;
      end
      SEQ_DIV: begin
        ctrl_o.busy = 1'b1;
        if (cnt_q == '0) begin
          ctrl_o.upd = 1'b1;
          state_d    = SEQ_IDLE;
        end
      end
      SEQ_IDLE: begin
        state_d = SEQ_IDLE;
      end
      default: begin
        state_d = SEQ_IDLE;
      end
    endcase
    // A register write restarts the division; the clearing pass ends in one anyway.
    if (cfg_write_i && state_q != SEQ_CLEAR) begin
      state_d = SEQ_LOAD;
    end
  end

  // State register and clearing address.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SEQ_CLEAR;
      clr_addr_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == SEQ_CLEAR) begin
        clr_addr_q <= clr_addr_q + XW'(1);
      end
    end
  end

  // Division registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      nq_q  <= '0;
      nc_q  <= '0;
      rq_q  <= '0;
      rc_q  <= '0;
    end else if (state_q == SEQ_LOAD) begin
      cnt_q <= CNTW'(POS_W - 1);
      nq_q  <= q_i;
      nc_q  <= c_i;
      rq_q  <= '0;
      rc_q  <= '0;
    end else if (state_q == SEQ_DIV) begin
      cnt_q <= cnt_q - CNTW'(1);
      nq_q  <= nq_d;
      nc_q  <= nc_d;
      rq_q  <= rq_d;
      rc_q  <= rc_d;
    end
  end

endmodule

// ===== sv/bm3_pipe.sv =====
// Window stage and result register: forms the 3x3 window from the line store data,
// applies erosion or dilation, counts set results. Depends on bm3_pkg, bm3_out_if.
module bm3_pipe import bm3_pkg::*; #(
  parameter int XW = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            acc_i,
  input  bm3_item_t       item_i,
  input  logic [XW-1:0]   x_i,
  input  morph_mode_e     mode_i,
  input  logic [LS_W-1:0] ls_rdata_i,
  output logic            s1_ready_o,
  output logic            wr_en_o,
  output logic [XW-1:0]   wr_addr_o,
  output logic [LS_W-1:0] wr_data_o,
  bm3_out_if.source       out_ch
);

  logic              s1_valid_q;
  bm3_item_t         s1_item_q;
  logic [XW-1:0]     s1_x_q;
  logic              s1_adv;
  logic              byp_q;
  logic [LS_W-1:0]   byp_data_q;
  logic [LS_W-1:0]   ls_word;
  logic [WIN_N-1:0]  win_q, win_d;
  logic [2:0]        col;
  logic              hit, res;
  logic [ONES_W-1:0] ones_q, ones_inc;
  logic              out_valid_q;
  logic              pix_out_q, frame_end_q;
  logic [ONES_W-1:0] set_total_q;

  // The stage moves on unless its result must wait for a full result register.
  assign s1_adv = s1_valid_q &&
                  (!s1_item_q.produce || !out_valid_q || out_ch.ready);
  assign s1_ready_o = !s1_valid_q || s1_adv;

  // A transaction that reads the column written by the stage in the same cycle takes
  // the written word, since the RAM returns the old one.
  assign ls_word = byp_q ? byp_data_q : ls_rdata_i;

  // New window column: upper row, middle row, incoming pixel.
  always_comb begin
    col      = {s1_item_q.pix, ls_word[1], ls_word[0]};
    win_d    = {win_q[WIN_N-4:0], col};
    hit      = (mode_i == MODE_DILATE) ? (win_d != '0) : (win_d == WIN_FULL);
    res      = s1_item_q.interior && hit;
    ones_inc = (res && ones_q != ONES_MAX) ? ones_q + ONES_W'(1) : ones_q;
  end

  // Line store update: middle row moves up, the new pixel becomes the middle row.
  assign wr_en_o   = s1_adv;
  assign wr_addr_o = s1_x_q;
  assign wr_data_o = {s1_item_q.pix, ls_word[1]};

  // Control state of the window stage and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      win_q       <= '0;
      ones_q      <= '0;
    end else begin
      if (acc_i) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv && s1_item_q.produce) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        win_q <= win_d;
        if (s1_item_q.produce) begin
          ones_q <= s1_item_q.last ? '0 : ones_inc;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_item_q  <= item_i;
      s1_x_q     <= x_i;
      byp_q      <= s1_adv && (x_i == s1_x_q);
      byp_data_q <= wr_data_o;
    end
    if (s1_adv && s1_item_q.produce) begin
      pix_out_q   <= res;
      frame_end_q <= s1_item_q.last;
      set_total_q <= ones_inc;
    end
  end

  assign out_ch.valid     = out_valid_q;
  assign out_ch.pixel_out = pix_out_q;
  assign out_ch.frame_end = frame_end_q;
  assign out_ch.set_total = set_total_q;

endmodule

// ===== test/binary_morphology_3x3_tb.sv =====
// Self-checking testbench for the streaming 3x3 binary erosion/dilation block.
// Depends on bm3_pkg, the bm3_in_if and bm3_out_if interfaces and binary_morphology_3x3.
// A queue-fed driver, a stalling receiver and a predicting monitor check every result.
module binary_morphology_3x3_tb;
  import bm3_pkg::*;

  typedef struct packed {
    logic pix;
    logic drain;
  } pixel_item_t;

  typedef struct packed {
    logic              pix;
    logic              frame_end;
    logic [ONES_W-1:0] set_total;
  } morph_result_t;

  logic                 clk_i  = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  bm3_in_if  in_ch ();
  bm3_out_if out_ch ();

  binary_morphology_3x3 dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  // Clock with a period of 12 time units.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor state: its own copy of the line stores, window, positions and registers.
  bit                line_upper  [BM3_MAX_WIDTH];
  bit                line_middle [BM3_MAX_WIDTH];
  logic [WIN_N-1:0]  window_q   = '0;
  int unsigned       pix_pos    = 0;
  int unsigned       res_pos    = 0;
  logic [ONES_W-1:0] ones_seen  = '0;
  logic [CFG_W-1:0]  width_reg  = FW_RESET;
  logic [CFG_W-1:0]  height_reg = FH_RESET;
  morph_mode_e       mode_reg   = MODE_ERODE;

  pixel_item_t   pixel_q[$];
  morph_result_t expected_q[$];
  logic          in_fired   = 1'b0;
  int            error_cnt  = 0;
  int            result_idx = 0;
  int            item_total = 0;

  // Frame sides are used clamped to the range the line stores allow.
  function automatic int clamp_side(input logic [CFG_W-1:0] v, input int hi);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advances the predicted block by one accepted pixel; returns 1 when a result is due.
  function automatic bit morph_step(input pixel_item_t item, output morph_result_t res);
    int unsigned w, h, area, q, x, c, cx, cy;
    logic        pix, val, last;
    w    = clamp_side(width_reg, BM3_MAX_WIDTH);
    h    = clamp_side(height_reg, BM3_MAX_HEIGHT);
    area = w * h;
    q    = pix_pos;
    x    = q % w;
    res  = '0;
    // Drains inside the frame and anything past it enter the window as 0.
    pix = (!item.drain && q < area) ? item.pix : 1'b0;
    window_q = {window_q[WIN_N-4:0], pix, line_middle[x], line_upper[x]};
    line_upper[x]  = line_middle[x];
    line_middle[x] = pix;
    if (pix_pos != 32'hFFFF_FFFF) pix_pos++;
    if (q < w + 1) return 1'b0;
    c    = res_pos;
    cx   = c % w;
    cy   = c / w;
    last = (c >= area - 1);
    val  = 1'b0;
    if (cy != 0 && cy < h - 1 && cx != 0 && cx != w - 1) begin
      if (mode_reg == MODE_DILATE) val = |window_q;
      else val = (window_q == WIN_FULL);
    end
    if (val && ones_seen != ONES_MAX) ones_seen++;
    res.pix       = val;
    res.frame_end = last;
    res.set_total = ones_seen;
    if (last) begin
      pix_pos   = 0;
      res_pos   = 0;
      ones_seen = '0;
    end else begin
      res_pos++;
    end
    return 1'b1;
  endfunction

  // One line per mismatch; printing is capped so a broken block cannot flood the log.
  task automatic report_mismatch(input string msg);
    error_cnt++;
    if (error_cnt <= 100) $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // Monitor: predicts on every input transaction, then checks every output transaction.
  always @(posedge clk_i) begin
    pixel_item_t   taken;
    morph_result_t want, got;
    if (!rst_ni) begin
      in_fired = 1'b0;
    end else begin
      in_fired = in_ch.valid && in_ch.ready;
      taken    = {in_ch.pixel_in, in_ch.drain};
      if (in_fired && morph_step(taken, want)) expected_q.push_back(want);
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.pixel_out, out_ch.frame_end, out_ch.set_total};
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with none predicted", result_idx));
        end else begin
          want = expected_q.pop_front();
          if (got.pix !== want.pix)
            report_mismatch($sformatf("result %0d: pixel_out %b, predicted %b",
                                      result_idx, got.pix, want.pix));
          if (got.frame_end !== want.frame_end)
            report_mismatch($sformatf("result %0d: frame_end %b, predicted %b",
                                      result_idx, got.frame_end, want.frame_end));
          if (got.set_total !== want.set_total)
            report_mismatch($sformatf("result %0d: set_total %0d, predicted %0d",
                                      result_idx, got.set_total, want.set_total));
        end
        result_idx++;
      end
    end
  end

  // Driver: sends queued pixels in bursts of random length with random gaps between them.
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk_i) begin
    pixel_item_t nxt;
    if (rst_ni && (!in_ch.valid || in_fired)) begin
      if (gap_left != 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pixel_q.size() != 0) begin
        nxt = pixel_q.pop_front();
        in_ch.valid    <= 1'b1;
        in_ch.pixel_in <= nxt.pix;
        in_ch.drain    <= nxt.drain;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 48);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: always ready, randomly stalling, or following a rotating bit pattern.
  int          stall_mode = 0;
  int          stall_left = 0;
  logic [15:0] stall_pat  = 16'hFFFF;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(16, 160);
        stall_pat  = 16'($urandom) | 16'h0001;
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
        default: out_ch.ready <= stall_pat[stall_left % 16];
      endcase
    end
  end

  // Register write on the configuration port; the predictor follows at once.
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_FRAME_WIDTH:  width_reg  = value;
      CFG_FRAME_HEIGHT: height_reg = value;
      default:          mode_reg   = morph_mode_e'(value[0]);
    endcase
  endtask

  // The mode write carries random upper data bits, which the register must ignore.
  task automatic set_mode(input morph_mode_e m);
    logic [CFG_W-1:0] data;
    data    = CFG_W'($urandom);
    data[0] = m;
    write_reg(CFG_MORPH_MODE, data);
  endtask

  task automatic push_item(input logic pix, input logic drain);
    pixel_q.push_back(pixel_item_t'({pix, drain}));
    item_total++;
  endtask

  // Queues the transactions that take the block from its present position to the end
  // of the frame (or a random part of them, or at most limit of them when limit is not
  // zero); only valid while the block is idle.
  task automatic queue_frame(input int density, input int noise, input bit partial,
                             input int limit);
    int unsigned w, h, area, lead, need, i;
    int          n;
    pixel_item_t it;
    w    = clamp_side(width_reg, BM3_MAX_WIDTH);
    h    = clamp_side(height_reg, BM3_MAX_HEIGHT);
    area = w * h;
    lead = (pix_pos < w + 1) ? w + 1 - pix_pos : 0;
    need = lead + ((res_pos >= area - 1) ? 1 : area - res_pos);
    n    = (partial && need > 1) ? $urandom_range(1, need - 1) : need;
    if (limit > 0 && n > limit) n = limit;
    for (i = 0; i < n; i++) begin
      if (pix_pos + i < area) begin
        it.drain = ($urandom_range(0, 99) < noise);
        it.pix   = ($urandom_range(0, 99) < density);
      end else begin
        // Flush: mostly drains, now and then a stray pixel that must be ignored.
        it.drain = !($urandom_range(0, 99) < noise);
        it.pix   = $urandom_range(0, 1);
      end
      pixel_q.push_back(it);
      item_total++;
    end
  endtask

  // Waits until every pixel is accepted and every result has arrived, then lets the
  // pipeline run dry.
  task automatic settle_block();
    int guard;
    guard = 0;
    while ((pixel_q.size() != 0 || in_ch.valid || expected_q.size() != 0) &&
           guard < 400000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);
  endtask

  // Stimulus: directed frames, then random frames and settings with extreme sizes, cut
  // short and finished at a small size, in between.
  initial begin
    int density_opts[6];
    int phase;
    density_opts = '{0, 5, 30, 50, 90, 100};
    in_ch.valid    = 1'b0;
    in_ch.pixel_in = 1'b0;
    in_ch.drain    = 1'b0;
    out_ch.ready   = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_FRAME_WIDTH;
    cfg_data_i     = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Smallest frame in erosion, all pixels set, flushed by drain transactions.
    write_reg(CFG_FRAME_WIDTH, 11'd3);
    write_reg(CFG_FRAME_HEIGHT, 11'd3);
    set_mode(MODE_ERODE);
    repeat (9) push_item(1'b1, 1'b0);
    repeat (4) push_item(1'b1, 1'b1);
    settle_block();

    // Dilation of one corner pixel; a drain at the centre reads as 0, and set pixels
    // sent after the frame are ignored.
    set_mode(MODE_DILATE);
    push_item(1'b1, 1'b0);
    repeat (3) push_item(1'b0, 1'b0);
    push_item(1'b1, 1'b1);
    repeat (4) push_item(1'b0, 1'b0);
    repeat (4) push_item(1'b1, 1'b0);
    settle_block();

    phase = 0;
    while (item_total < 1400 || phase < 16) begin
      case (phase)
        2: begin
          // Widest line store: a long stretch without results, then a small frame.
          write_reg(CFG_FRAME_WIDTH, 11'd1024);
          write_reg(CFG_FRAME_HEIGHT, 11'd3);
          set_mode(MODE_ERODE);
          queue_frame(97, 1, 1'b0, 520);
          settle_block();
          write_reg(CFG_FRAME_WIDTH, 11'd5);
          write_reg(CFG_FRAME_HEIGHT, 11'd4);
          queue_frame(97, 1, 1'b0, 0);
        end
        7: begin
          // Sizes clamped from above and from below.
          write_reg(CFG_FRAME_WIDTH, 11'd2047);
          write_reg(CFG_FRAME_HEIGHT, 11'd0);
          set_mode(MODE_DILATE);
          queue_frame(3, 2, 1'b0, 40);
          settle_block();
          write_reg(CFG_FRAME_WIDTH, 11'd6);
          write_reg(CFG_FRAME_HEIGHT, 11'd3);
          queue_frame(3, 2, 1'b0, 0);
        end
        12: begin
          // Narrowest frame with the tallest height, ended early by a smaller height.
          write_reg(CFG_FRAME_WIDTH, 11'd1);
          write_reg(CFG_FRAME_HEIGHT, 11'd2047);
          set_mode(MODE_ERODE);
          queue_frame(100, 0, 1'b0, 60);
          settle_block();
          write_reg(CFG_FRAME_HEIGHT, 11'd5);
          queue_frame(100, 0, 1'b0, 0);
        end
        default: begin
          // Settings change now and then, possibly in the middle of a frame.
          if ($urandom_range(0, 4) < 3) begin
            if ($urandom_range(0, 1))
              write_reg(CFG_FRAME_WIDTH, ($urandom_range(0, 7) == 0) ?
                        CFG_W'($urandom_range(0, 2)) : CFG_W'($urandom_range(3, 12)));
            if ($urandom_range(0, 1))
              write_reg(CFG_FRAME_HEIGHT, ($urandom_range(0, 7) == 0) ?
                        CFG_W'($urandom_range(0, 2)) : CFG_W'($urandom_range(3, 10)));
            if ($urandom_range(0, 1))
              set_mode(morph_mode_e'($urandom_range(0, 1)));
          end
          queue_frame(density_opts[$urandom_range(0, 5)],
                      $urandom_range(0, 1) ? 0 : $urandom_range(1, 8),
                      ($urandom_range(0, 4) == 0), 0);
        end
      endcase
      settle_block();
      phase++;
    end

    if (expected_q.size() != 0)
      report_mismatch($sformatf("%0d predicted results never arrived", expected_q.size()));
    if (error_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #24000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
